// ===== rtl/core/tmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tmb_pkg;

  // input field widths that do not vary
  localparam int PIX_IN_W = 16;
  localparam int WIN_W    = 5;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_WINDOW = 1'b0;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd15;

  typedef enum logic [1:0] {
    ACT_ADD        = 2'd0,
    ACT_REBUILD    = 2'd1,
    ACT_FOREGROUND = 2'd2
  } action_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_WRAP = 7'b0000010,
    ST_BASE = 7'b0000100,
    ST_ACT  = 7'b0001000,
    ST_SORT = 7'b0010000,
    ST_MED  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } srt_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/temporal_median_background.sv =====
// Sequence: a word passes the wrap steps (only if PIXELS < 65536), BASE, ACT and DONE;
//   a rebuild over n > 0 held frames also reads them into the sorter in SORT and takes the median in MED.
// Throughput: one word at a time; the next is taken once the last result is registered for output,
//   and a rebuild reads its frames one by one through the single history memory read port.
// Reset (rst_n, synchronous) clears the sequencer, frame slot, frame count and output
//   valid, and loads window_frames = 15; history and background memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module temporal_median_background import tmb_pkg::*; #(
  parameter int PIXELS      = 65536,
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // in_tdata: pixel_index[15:0], sample[16+SAMPLE_BITS-1:16], zero pad
  input  wire logic [((PIX_IN_W+SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // in_tuser: action
  input  wire logic [1:0]     in_tuser,
  // in_tlast: end_of_frame
  input  wire                 in_tlast,
  input  wire                 in_tvalid,
  output logic                in_tready,
  // out_tdata: background[SB-1:0], foreground[2SB:SB], frames_in_window[2SB+5:2SB+1], zero pad
  output logic [((2*SAMPLE_BITS+1+WIN_W+7)/8)*8-1:0] out_tdata,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  wire                 cfg_psel,
  input  wire                 cfg_penable,
  input  wire                 cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  localparam int PIX_AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int HIST_DEPTH = PIXELS * WINDOW_MAX;
  localparam int HAW        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int OUT_FW     = 2 * SAMPLE_BITS + 1 + WIN_W;
  localparam int OUT_W      = ((OUT_FW + 7) / 8) * 8;
  localparam int WRAP_STEPS = (PIXELS > 65535) ? 0 : $clog2(65535 / PIXELS + 1);
  localparam longint DIV_INIT = longint'(PIXELS) << ((WRAP_STEPS > 0) ? WRAP_STEPS - 1 : 0);
  localparam logic [6:0] WMAX7 = 7'(WINDOW_MAX);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);

  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    if (w == '0) begin
      r = WIN_W'(1);
    end else if ({2'b00, w} > WMAX7) begin
      r = WIN_W'(WINDOW_MAX);
    end else begin
      r = w;
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic [1:0]                    action_r;
  logic                          eof_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [PIX_IN_W-1:0]           wrap_r;
  logic [PIX_IN_W:0]             div_r;
  logic [4:0]                    wcnt_r;
  logic [PIX_AW-1:0]             pix_w;
  logic [PIX_AW-1:0]             pix_r;
  logic [HAW-1:0]                hbase_r;
  logic [SLOT_W-1:0]             slot_r;
  logic [SLOT_W-1:0]             rd_slot_r;
  logic [WIN_W-1:0]              rd_left_r;
  logic                          hq_v_r;
  logic [WIN_W-1:0]              frames_r;
  logic [WIN_W-1:0]              win_r;
  logic [WIN_W-1:0]              eff_w;
  logic signed [SAMPLE_BITS-1:0] bg_val_r;
  logic signed [SAMPLE_BITS:0]   fg;
  logic [OUT_W-1:0]              out_data_r;
  logic                          out_valid_r;

  logic [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [SAMPLE_BITS-1:0] bg_mem [PIXELS];
  logic [SAMPLE_BITS-1:0] hist_q;
  logic [SAMPLE_BITS-1:0] bg_q;
  logic                   hist_we;
  logic                   bg_we;
  logic [SAMPLE_BITS-1:0] bg_wdata;
  logic [HAW-1:0]         hist_waddr;
  logic [HAW-1:0]         hist_raddr;
  logic                   issue;
  logic                   in_acc;
  logic                   cfg_we;

  srt_ctl_t                      srt_ctl;
  logic [SLOT_W-1:0]             rank;
  logic signed [SAMPLE_BITS-1:0] rank_data;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_WINDOW);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW) ? CFG_DW'(win_r) : '0;

  assign eff_w      = eff_window(win_r);
  assign pix_w      = PIX_AW'(wrap_r);
  assign hist_waddr = hbase_r + HAW'(slot_r);
  assign hist_raddr = hbase_r + HAW'(rd_slot_r);
  assign issue      = (state_r == ST_SORT) && (rd_left_r != '0);
  assign rank       = SLOT_W'(frames_r >> 1);

  assign srt_ctl.clear  = (state_r == ST_ACT);
  assign srt_ctl.insert = hq_v_r;

  assign hist_we = (state_r == ST_ACT) && (action_r == ACT_ADD);

  always_comb begin
    bg_we    = 1'b0;
    bg_wdata = rank_data;
    if (state_r == ST_MED) begin
      bg_we = 1'b1;
    end else if (state_r == ST_ACT && action_r == ACT_REBUILD && frames_r == '0) begin
      bg_we    = 1'b1;
      bg_wdata = '0;
    end
  end

  assign fg = (action_r == ACT_FOREGROUND) ?
              ($signed({sample_r[SAMPLE_BITS-1], sample_r}) -
               $signed({bg_val_r[SAMPLE_BITS-1], bg_val_r})) : '0;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= sample_r;
    end
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (bg_we) begin
      bg_mem[pix_r] <= bg_wdata;
    end
    bg_q <= bg_mem[pix_w];
  end

  tmb_sorter #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS),
    .RANK_W     (SLOT_W)
  ) u_sorter (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (srt_ctl),
    .ins_data ($signed(hist_q)),
    .rank     (rank),
    .rank_data(rank_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (WRAP_STEPS > 0) ? ST_WRAP : ST_BASE;
        end
      end
      ST_WRAP: begin
        if (wcnt_r == 5'd1) begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: state_nxt = ST_ACT;
      ST_ACT: begin
        if (action_r == ACT_REBUILD && frames_r != '0) begin
          state_nxt = ST_SORT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SORT: begin
        if (rd_left_r == '0 && !hq_v_r) begin
          state_nxt = ST_MED;
        end
      end
      ST_MED: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      frames_r    <= '0;
      win_r       <= WINDOW_RESET;
      wcnt_r      <= '0;
      rd_left_r   <= '0;
      hq_v_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hq_v_r  <= issue;
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        wcnt_r <= 5'(WRAP_STEPS);
      end else if (state_r == ST_WRAP) begin
        wcnt_r <= wcnt_r - 5'd1;
      end
      if (state_r == ST_ACT) begin
        rd_left_r <= frames_r;
      end else if (issue) begin
        rd_left_r <= rd_left_r - WIN_W'(1);
      end
      // close the frame: advance the slot and count it up to the window
      if (hist_we && eof_r) begin
        slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
        if (frames_r < eff_w) begin
          frames_r <= frames_r + WIN_W'(1);
        end
      end
      if (cfg_we) begin
        win_r <= cfg_pwdata[WIN_W-1:0];
        if (frames_r > eff_window(cfg_pwdata[WIN_W-1:0])) begin
          frames_r <= eff_window(cfg_pwdata[WIN_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= in_tuser;
      eof_r    <= in_tlast;
      sample_r <= $signed(in_tdata[PIX_IN_W +: SAMPLE_BITS]);
      wrap_r   <= in_tdata[PIX_IN_W-1:0];
      div_r    <= (PIX_IN_W + 1)'(DIV_INIT);
    end
    // restoring reduction of the pixel index, one shifted subtract per cycle
    if (state_r == ST_WRAP) begin
      if ({1'b0, wrap_r} >= div_r) begin
        wrap_r <= wrap_r - div_r[PIX_IN_W-1:0];
      end
      div_r <= div_r >> 1;
    end
    if (state_r == ST_BASE) begin
      pix_r   <= pix_w;
      hbase_r <= HAW'(pix_w) * HAW'(WINDOW_MAX);
    end
    if (state_r == ST_ACT) begin
      bg_val_r  <= (action_r == ACT_REBUILD) ? '0 : $signed(bg_q);
      rd_slot_r <= (slot_r == '0) ? SLOT_LAST : slot_r - SLOT_W'(1);
    end else if (issue) begin
      rd_slot_r <= (rd_slot_r == '0) ? SLOT_LAST : rd_slot_r - SLOT_W'(1);
    end
    if (state_r == ST_MED) begin
      bg_val_r <= rank_data;
    end
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= OUT_W'({frames_r, fg, bg_val_r});
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tmb_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmb_sorter import tmb_pkg::*; #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int RANK_W      = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire srt_ctl_t                 ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] ins_data,
  input  wire logic [RANK_W-1:0]        rank,
  output logic signed [SAMPLE_BITS-1:0] rank_data
);

  logic signed [SAMPLE_BITS-1:0] cell_r [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]         vld_r;
  logic [WINDOW_MAX-1:0]         gt;

  // a cell is above the new word when it is empty or holds a larger value
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      gt[i] = !vld_r[i] || (cell_r[i] > ins_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      vld_r <= '0;
    end else if (ctl.insert) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (gt[i]) begin
          if (i == 0) begin
            vld_r[i] <= 1'b1;
          end else if (!gt[i-1]) begin
            vld_r[i] <= 1'b1;
          end else begin
            vld_r[i] <= vld_r[i-1];
          end
        end
      end
    end
  end

  // shift the larger part of the sorted row up by one and drop the word in the gap
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (gt[i]) begin
          if (i == 0) begin
            cell_r[i] <= ins_data;
          end else if (!gt[i-1]) begin
            cell_r[i] <= ins_data;
          end else begin
            cell_r[i] <= cell_r[i-1];
          end
        end
      end
    end
  end

  assign rank_data = cell_r[rank];

endmodule
`default_nettype wire

// ===== rtl/core/tmb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmb_checker #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input wire clk,
  input wire rst_n,
  input wire in_tvalid,
  input wire in_tready,
  input wire out_tvalid,
  input wire out_tready,
  input wire logic [((2*SAMPLE_BITS+6+7)/8)*8-1:0] out_tdata
);

  localparam int FR_LO = 2 * SAMPLE_BITS + 1;

  // a result word waits until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // one word in flight: the input closes right after a word is taken
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in flight");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_frames_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[FR_LO+4:FR_LO] <= WINDOW_MAX))
    else $error("frame count beyond window");

endmodule

bind temporal_median_background tmb_checker #(
  .WINDOW_MAX (WINDOW_MAX),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_tmb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire
